>>> rtl/spq_pkg.sv
// Shared operation and status codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

    typedef logic [1:0] func_t;
    typedef logic [1:0] status_t;

    localparam func_t FUNC_PUSH = 2'd0;
    localparam func_t FUNC_POP  = 2'd1;
    localparam func_t FUNC_TOP  = 2'd2;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

>>> rtl/spq_mem.sv
// Entry storage for the sorted priority queue: one write port, one registered read port.
`default_nettype none

module spq_mem #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/spq_ctrl.sv
// Sequencer of the sorted priority queue: ring pointers, insertion scan and result register.
`default_nettype none

module spq_ctrl #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16,
    parameter int PTR_W          = 4,
    parameter int CNT_W          = 5
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             order_mode,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire spq_pkg::func_t                   s_func,
    input  wire logic signed [VALUE_WIDTH-1:0]    s_value,
    input  wire logic signed [PRIORITY_WIDTH-1:0] s_priority,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [VALUE_WIDTH-1:0]         m_value,
    output logic signed [PRIORITY_WIDTH-1:0]      m_priority,
    output spq_pkg::status_t                      m_status,
    output logic [CNT_W-1:0]                      m_count,
    output logic                                  mem_wr_en,
    output logic [PTR_W-1:0]                      mem_wr_addr,
    output logic [VALUE_WIDTH+PRIORITY_WIDTH-1:0] mem_wr_data,
    output logic                                  mem_rd_en,
    output logic [PTR_W-1:0]                      mem_rd_addr,
    input  wire logic [VALUE_WIDTH+PRIORITY_WIDTH-1:0] mem_rd_data
);

    import spq_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_PLACE = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    logic [2:0]                         state_reg, state_next;
    func_t                              func_reg, func_next;
    logic signed [PRIORITY_WIDTH-1:0]   pri_reg, pri_next;
    logic [VALUE_WIDTH+PRIORITY_WIDTH-1:0] carry_reg, carry_next;
    logic                               found_reg, found_next;
    logic [PTR_W-1:0]                   head_reg, head_next;
    logic [PTR_W-1:0]                   tail_reg, tail_next;
    logic [PTR_W-1:0]                   pos_reg, pos_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [CNT_W-1:0]                   left_reg, left_next;
    status_t                            res_status_reg, res_status_next;
    logic signed [VALUE_WIDTH-1:0]      res_val_reg, res_val_next;
    logic signed [PRIORITY_WIDTH-1:0]   res_pri_reg, res_pri_next;
    logic                               out_valid_reg, out_valid_next;
    status_t                            out_status_reg, out_status_next;
    logic signed [VALUE_WIDTH-1:0]      out_val_reg, out_val_next;
    logic signed [PRIORITY_WIDTH-1:0]   out_pri_reg, out_pri_next;
    logic [CNT_W-1:0]                   out_count_reg, out_count_next;

    logic [PTR_W-1:0]                   head_inc;
    logic [PTR_W-1:0]                   tail_inc;
    logic [PTR_W-1:0]                   pos_inc;
    logic signed [VALUE_WIDTH-1:0]      rd_val;
    logic signed [PRIORITY_WIDTH-1:0]   rd_pri;
    logic                               goes_first;

    assign head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc = (tail_reg == LAST_SLOT) ? '0 : tail_reg + PTR_W'(1);
    assign pos_inc  = (pos_reg == LAST_SLOT) ? '0 : pos_reg + PTR_W'(1);

    assign rd_val = mem_rd_data[VALUE_WIDTH-1:0];
    assign rd_pri = mem_rd_data[VALUE_WIDTH +: PRIORITY_WIDTH];

    // The stored entry stays ahead of the new one when it is served before it or ties.
    assign goes_first = order_mode ? (rd_pri >= pri_reg) : (rd_pri <= pri_reg);

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        pri_next        = pri_reg;
        carry_next      = carry_reg;
        found_next      = found_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        left_next       = left_reg;
        res_status_next = res_status_reg;
        res_val_next    = res_val_reg;
        res_pri_next    = res_pri_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_val_next    = out_val_reg;
        out_pri_next    = out_pri_reg;
        out_count_next  = out_count_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = pos_inc;
        mem_wr_data     = carry_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    func_next       = s_func;
                    pri_next        = s_priority;
                    res_status_next = STATUS_OK;
                    res_val_next    = '0;
                    res_pri_next    = '0;
                    state_next      = ST_DONE;
                    case (s_func) inside
                        FUNC_PUSH:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = tail_reg;
                                mem_wr_data = {s_priority, s_value};
                                count_next  = count_reg + ONE_CNT;
                                tail_next   = tail_inc;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = head_reg;
                                pos_next    = head_reg;
                                left_next   = count_reg;
                                carry_next  = {s_priority, s_value};
                                found_next  = 1'b0;
                                state_next  = ST_SCAN;
                            end
                        end
                        FUNC_POP, FUNC_TOP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = head_reg;
                                state_next  = ST_READ;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_val_next = rd_val;
                res_pri_next = rd_pri;
                if (func_reg == FUNC_POP)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - ONE_CNT;
                end
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                // From the first entry that the new one goes ahead of, every entry moves back.
                if (found_reg || !goes_first)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pos_reg;
                    mem_wr_data = carry_reg;
                    carry_next  = mem_rd_data;
                    found_next  = 1'b1;
                end
                if (left_reg == ONE_CNT)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = pos_inc;
                    pos_next    = pos_inc;
                    left_next   = left_reg - ONE_CNT;
                end
            end
            ST_PLACE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = pos_inc;
                mem_wr_data = carry_reg;
                count_next  = count_reg + ONE_CNT;
                tail_next   = tail_inc;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_val_next    = res_val_reg;
                    out_pri_next    = res_pri_reg;
                    out_count_next  = count_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        pri_reg        <= pri_next;
        carry_reg      <= carry_next;
        found_reg      <= found_next;
        pos_reg        <= pos_next;
        left_reg       <= left_next;
        res_status_reg <= res_status_next;
        res_val_reg    <= res_val_next;
        res_pri_reg    <= res_pri_next;
        out_status_reg <= out_status_next;
        out_val_reg    <= out_val_next;
        out_pri_reg    <= out_pri_next;
        out_count_reg  <= out_count_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = out_valid_reg;
    assign m_value    = out_val_reg;
    assign m_priority = out_pri_reg;
    assign m_status   = out_status_reg;
    assign m_count    = out_count_reg;

endmodule

`default_nettype wire

>>> rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: stream ports, order register and entry memory.
// Push on an empty or full queue and the unused code go from idle straight to the result;
// pop and top first read the head entry, and a push into a non-empty queue first scans every stored entry.
// The insertion scan visits one stored entry per cycle through the single memory port pair.
// A new transaction is taken the cycle after the result is loaded into the output register.
// Reset clears the count, ring pointers, order mode and output valid; entries are not cleared.
`default_nettype none

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16,
    localparam int PTR_W  = $clog2(QUEUE_DEPTH),
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_DW  = ((VALUE_WIDTH + PRIORITY_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((VALUE_WIDTH + PRIORITY_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_DW-1:0]  s_tdata,   // item_value, item_priority
    input  wire spq_pkg::func_t    s_tuser,   // func
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_DW-1:0]      m_tdata,   // head_value, head_priority, entry_count
    output spq_pkg::status_t       m_tuser,   // status
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data
);

    import spq_pkg::*;

    localparam int ENTRY_W = VALUE_WIDTH + PRIORITY_WIDTH;

    logic                               order_mode_reg;
    logic signed [VALUE_WIDTH-1:0]      head_value;
    logic signed [PRIORITY_WIDTH-1:0]   head_priority;
    logic [CNT_W-1:0]                   entry_count;
    logic                               mem_wr_en;
    logic [PTR_W-1:0]                   mem_wr_addr;
    logic [ENTRY_W-1:0]                 mem_wr_data;
    logic                               mem_rd_en;
    logic [PTR_W-1:0]                   mem_rd_addr;
    logic [ENTRY_W-1:0]                 mem_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            order_mode_reg <= cfg_data;
        end
    end

    spq_ctrl #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .VALUE_WIDTH    (VALUE_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH),
        .PTR_W          (PTR_W),
        .CNT_W          (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .order_mode  (order_mode_reg),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_func      (s_tuser),
        .s_value     (s_tdata[VALUE_WIDTH-1:0]),
        .s_priority  (s_tdata[VALUE_WIDTH +: PRIORITY_WIDTH]),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_value     (head_value),
        .m_priority  (head_priority),
        .m_status    (m_tuser),
        .m_count     (entry_count),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    spq_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (PTR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign m_tdata = OUT_DW'({entry_count, head_priority, head_value});

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_FULL) |-> entry_count == CNT_W'(QUEUE_DEPTH))
        else $error("Full status reported with a queue that is not full.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_EMPTY) |->
            (entry_count == '0) && (head_value == '0) && (head_priority == '0))
        else $error("Empty status reported with entries or head data.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> entry_count <= CNT_W'(QUEUE_DEPTH))
        else $error("Entry count exceeds the queue depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
        else $error("Memory read and write collide on one entry.");

endmodule

`default_nettype wire
